// File: rtl/gww_pkg.sv
package gww_pkg;

  // Text bytes with special meaning
  localparam logic [7:0] CH_NUL     = 8'd0;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  // Field widths
  localparam int IDX_W = 12;
  localparam int PIX_W = 16;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CHAR_ADVANCE = 2'd0,
    REG_WRAP_WIDTH   = 2'd1,
    REG_LINE_HEIGHT  = 2'd2,
    REG_ORIGIN_Y     = 2'd3
  } reg_index_t;

  // Register values after reset
  localparam logic [7:0]       RST_CHAR_ADVANCE = 8'd6;
  localparam logic [PIX_W-1:0] RST_WRAP_WIDTH   = 16'd128;
  localparam logic [7:0]       RST_LINE_HEIGHT  = 8'd9;
  localparam logic [PIX_W-1:0] RST_ORIGIN_Y     = 16'd0;

  localparam logic [PIX_W-1:0] PIX_MAX = '1;

endpackage

// File: rtl/greedy_word_wrap_unit.sv
// Channel  | valid      | stall      | payload
// ---------+------------+------------+---------------------------------------------
// text in  | ch_valid   | ch_stall   | ch
// spans    | span_valid | span_stall | span_start, span_length, span_y, span_empty,
//          |            |            | last, measured_height
// config   | wr_en      | (none)     | wr_index, wr_data
//
// One character per cycle sustained while spans are not stalled; a span is offered
// from the span register once its character has passed the input register.
// The text state is updated in one pass from the input register to the span register.
// Synchronous reset restores the register defaults and clears the text state.
// A stalled span holds the span register and stalls the input register behind it.
module greedy_word_wrap_unit #(
  parameter int MAX_TEXT = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  // text input
  input  logic                           ch_valid,
  output logic                           ch_stall,
  input  logic [7:0]                     ch,
  // span output
  output logic                           span_valid,
  input  logic                           span_stall,
  output logic [gww_pkg::IDX_W-1:0]      span_start,
  output logic [gww_pkg::IDX_W-1:0]      span_length,
  output logic [gww_pkg::PIX_W-1:0]      span_y,
  output logic                           span_empty,
  output logic                           last,
  output logic [gww_pkg::PIX_W-1:0]      measured_height,
  // configuration
  input  logic                           wr_en,
  input  logic [1:0]                     wr_index,
  input  logic [gww_pkg::PIX_W-1:0]      wr_data
);
  import gww_pkg::*;

  localparam int IDX_LIMIT = (MAX_TEXT - 1 < 4095) ? MAX_TEXT - 1 : 4095;

  function automatic logic [IDX_W-1:0] sat_idx(input logic [IDX_W:0] v);
    logic [IDX_W-1:0] r;
    begin
      r = (v > (IDX_W+1)'(IDX_LIMIT)) ? IDX_W'(IDX_LIMIT) : v[IDX_W-1:0];
      return r;
    end
  endfunction

  function automatic logic [PIX_W-1:0] sat_pix(input logic [PIX_W:0] v);
    logic [PIX_W-1:0] r;
    begin
      r = v[PIX_W] ? PIX_MAX : v[PIX_W-1:0];
      return r;
    end
  endfunction

  // Configuration registers
  logic [7:0]       char_advance;
  logic [PIX_W-1:0] wrap_width;
  logic [7:0]       line_height;
  logic [PIX_W-1:0] origin_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_advance <= RST_CHAR_ADVANCE;
      wrap_width   <= RST_WRAP_WIDTH;
      line_height  <= RST_LINE_HEIGHT;
      origin_y     <= RST_ORIGIN_Y;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_CHAR_ADVANCE: char_advance <= wr_data[7:0];
        REG_WRAP_WIDTH:   wrap_width   <= wr_data;
        REG_LINE_HEIGHT:  line_height  <= wr_data[7:0];
        REG_ORIGIN_Y:     origin_y     <= wr_data;
        default:          ;
      endcase
    end
  end

  // Input register
  logic       in_valid;
  logic [7:0] in_ch;
  logic       advance;
  logic       process;

  assign advance  = !span_valid || !span_stall;
  assign process  = in_valid && advance;
  assign ch_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!ch_stall) begin
      in_valid <= ch_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!ch_stall) begin
      in_ch <= ch;
    end
  end

  // Text state
  logic [IDX_W-1:0] char_index, line_start, last_space;
  logic             space_seen;
  logic [PIX_W-1:0] line_width, row_offset, counted_height;

  logic [IDX_W-1:0] char_index_next, line_start_next, last_space_next;
  logic             space_seen_next;
  logic [PIX_W-1:0] line_width_next, row_offset_next, counted_height_next;

  // Step logic
  logic             term, flush, is_space, wrap, emit;
  logic [PIX_W-1:0] width_acc;
  logic [IDX_W-1:0] space_pos, brk, len, new_start, idx_inc;
  logic             seen_acc;
  logic [IDX_W:0]   recount_n;
  logic [IDX_W+8:0] recount_w;
  logic [PIX_W-1:0] recount_sat, row_sum, height_sum, y_sum;

  always_comb begin
    term     = (in_ch == CH_NUL);
    flush    = term || (in_ch == CH_NEWLINE);
    is_space = (in_ch == CH_SPACE);
    idx_inc  = sat_idx({1'b0, char_index} + (IDX_W+1)'(1));

    // running width and break point with this character included
    width_acc = flush ? line_width
                      : sat_pix({1'b0, line_width} + (PIX_W+1)'(char_advance));
    space_pos = (is_space && !flush) ? char_index : last_space;
    seen_acc  = (is_space && !flush) || space_seen;

    wrap = !flush && (width_acc > wrap_width);
    emit = flush || wrap;

    brk = (!flush && seen_acc) ? space_pos : char_index;
    len = (brk >= line_start) ? brk - line_start : '0;

    y_sum      = sat_pix({1'b0, origin_y} + {1'b0, row_offset});
    row_sum    = sat_pix({1'b0, row_offset} + (PIX_W+1)'(line_height));
    height_sum = sat_pix({1'b0, counted_height} + (PIX_W+1)'(line_height));

    // recount width of the wrapped remainder
    new_start = seen_acc ? sat_idx({1'b0, space_pos} + (IDX_W+1)'(1)) : char_index;
    recount_n = {1'b0, char_index} - {1'b0, new_start} + (IDX_W+1)'(1);
    recount_w = recount_n * char_advance;
    if (char_index < new_start) begin
      recount_sat = '0;
    end else if (recount_w > (IDX_W+9)'(PIX_MAX)) begin
      recount_sat = PIX_MAX;
    end else begin
      recount_sat = recount_w[PIX_W-1:0];
    end

    // defaults: no result
    char_index_next     = idx_inc;
    line_start_next     = line_start;
    last_space_next     = space_pos;
    space_seen_next     = seen_acc;
    line_width_next     = width_acc;
    row_offset_next     = row_offset;
    counted_height_next = counted_height;

    if (emit) begin
      row_offset_next = row_sum;
      if (len != '0 || flush) begin
        counted_height_next = height_sum;
      end
      space_seen_next = 1'b0;
      if (flush) begin
        line_start_next = idx_inc;
        line_width_next = '0;
      end else begin
        line_start_next = new_start;
        line_width_next = recount_sat;
      end
      if (term) begin
        char_index_next     = '0;
        line_start_next     = '0;
        last_space_next     = '0;
        line_width_next     = '0;
        row_offset_next     = '0;
        counted_height_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_index     <= '0;
      line_start     <= '0;
      last_space     <= '0;
      space_seen     <= 1'b0;
      line_width     <= '0;
      row_offset     <= '0;
      counted_height <= '0;
    end else if (process) begin
      char_index     <= char_index_next;
      line_start     <= line_start_next;
      last_space     <= last_space_next;
      space_seen     <= space_seen_next;
      line_width     <= line_width_next;
      row_offset     <= row_offset_next;
      counted_height <= counted_height_next;
    end
  end

  // Span register
  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
    end else if (advance) begin
      span_valid <= process && emit;
    end
  end

  // the terminator always counts its own line, so its height is height_sum
  always_ff @(posedge clk) begin
    if (process && emit) begin
      span_start      <= line_start;
      span_length     <= len;
      span_y          <= y_sum;
      span_empty      <= (len == '0);
      last            <= term;
      measured_height <= term ? height_sum : '0;
    end
  end

`ifndef SYNTHESIS
  a_height_only_last: assert property (@(posedge clk) disable iff (rst)
    span_valid && !last |-> measured_height == '0)
    else $error("measured height set on a span that is not last");

  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    span_valid |-> span_empty == (span_length == '0))
    else $error("empty flag disagrees with span length");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    process && term |=> char_index == '0 && row_offset == '0 && counted_height == '0)
    else $error("text state not cleared after terminator");

  a_index_limit: assert property (@(posedge clk) disable iff (rst)
    char_index <= IDX_W'(IDX_LIMIT) && line_start <= IDX_W'(IDX_LIMIT))
    else $error("index beyond saturation limit");
`endif

endmodule
